/* hdl/xrpc_pkg.sv */
// ----------------------------------------------------------------------------
// xrpc_pkg
// Shared types and constants for the xor range pair counter: key and counter
// widths, trie store geometry, register indexes and the beat structs.
// ----------------------------------------------------------------------------
package xrpc_pkg;

    // key and counter geometry
    localparam int KEY_BITS   = 15;
    localparam int COUNT_BITS = 17;

    // fixed field widths of the ports
    localparam int VALUE_BITS = 15;
    localparam int RANGE_BITS = 15;
    localparam int TOTAL_BITS = 32;

    // full tree of prefix counters, depths 1..KEY_BITS
    localparam int NODE_COUNT = (2 << KEY_BITS) - 2;
    localparam int ADDR_W     = KEY_BITS + 1;
    localparam int LVL_W      = $clog2(KEY_BITS + 1);

    // a query sums at most KEY_BITS counters
    localparam int SUM_BITS   = COUNT_BITS + $clog2(KEY_BITS + 1);
    localparam int TOT_W      = ((SUM_BITS > TOTAL_BITS) ? SUM_BITS : TOTAL_BITS) + 1;

    // each store entry carries an epoch tag so a restart needs no sweep
    localparam int EPOCH_BITS = 4;
    localparam int ENTRY_W    = EPOCH_BITS + COUNT_BITS;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'b1;

    localparam logic [RANGE_BITS-1:0] RANGE_LOW_RST  = 15'd0;
    localparam logic [RANGE_BITS-1:0] RANGE_HIGH_RST = 15'd32766;

    // input beat
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  start_new;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [TOTAL_BITS-1:0] pair_total;
        logic                  saturated;
    } out_beat_t;

endpackage

/* hdl/xrpc_ram.sv */
// ----------------------------------------------------------------------------
// xrpc_ram
// Generic RAM with one write port and two read ports, registered read data.
// ----------------------------------------------------------------------------
module xrpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    output logic [WIDTH-1:0]         rdata0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

/* hdl/xor_range_pair_counter.sv */
// ----------------------------------------------------------------------------
// xor_range_pair_counter
// Counts, for each key, the earlier keys whose XOR with it lies in the
// configured range, and reports the saturating running total of such pairs.
// ----------------------------------------------------------------------------
// A key beat is taken only in the idle state, so the next key waits until the
// result of the last one is loaded: each key walks the trie through the QRY
// and INS states at every level, then FIN and TOT load the result beat; an
// untaken result holds the next one back. Each trie level uses the single
// two-read-port counter RAM in QRY and then in INS, first for the upper and
// lower bound walks, then for the insert read, while the insert write of the
// previous level shares the write port. Prefix counters live in one RAM entry
// per trie node, tagged with an epoch, so a start flag normally clears in no
// time. After reset, and on every fifteenth start flag when the epoch tag
// wraps, a clearing pass writes all NODE_COUNT = 65534 entries of the store,
// one entry a cycle, during which no key is taken; configuration writes are
// always taken and are meant to happen only while the block is idle.
module xor_range_pair_counter (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  xrpc_pkg::in_beat_t                  s_data,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output xrpc_pkg::out_beat_t                 m_data,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [xrpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [xrpc_pkg::RANGE_BITS-1:0]     cfg_data
);

    import xrpc_pkg::*;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_QRY,
        S_INS,
        S_FIN,
        S_TOT
    } state_t;

    // control registers
    state_t                  state_reg, state_next;
    logic                    m_valid_reg, m_valid_next;
    logic [EPOCH_BITS-1:0]   epoch_reg, epoch_next;
    logic                    pend_reg, pend_next;
    logic [ADDR_W-1:0]       clr_reg, clr_next;
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    logic [TOTAL_BITS-1:0]   total_reg, total_next;
    logic [COUNT_BITS-1:0]   cnt0_reg, cnt0_next;
    logic [COUNT_BITS-1:0]   cnt1_reg, cnt1_next;
    logic [RANGE_BITS-1:0]   range_low_reg, range_low_next;
    logic [RANGE_BITS-1:0]   range_high_reg, range_high_next;

    // datapath registers
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [RANGE_BITS:0]     bound_u_reg, bound_u_next;
    logic [RANGE_BITS:0]     bound_l_reg, bound_l_next;
    logic [KEY_BITS-1:0]     cur_u_reg, cur_u_next;
    logic [KEY_BITS-1:0]     cur_l_reg, cur_l_next;
    logic                    bu_reg, bu_next;
    logic                    bl_reg, bl_next;
    logic [SUM_BITS-1:0]     sum_u_reg, sum_u_next;
    logic [SUM_BITS-1:0]     sum_l_reg, sum_l_next;
    logic [ADDR_W-1:0]       ins_addr_reg, ins_addr_next;
    logic [SUM_BITS-1:0]     diff_reg, diff_next;
    out_beat_t               m_data_reg, m_data_next;

    // ram ports
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr0;
    logic [ADDR_W-1:0]       ram_raddr1;
    logic [ENTRY_W-1:0]      ram_rdata0;
    logic [ENTRY_W-1:0]      ram_rdata1;

    // per-level helpers
    logic [LVL_W-1:0]        shamt;
    logic                    kb;
    logic                    bit_u;
    logic                    bit_l;
    logic [COUNT_BITS-1:0]   cnt_rd0;
    logic [COUNT_BITS-1:0]   cnt_rd1;
    logic [COUNT_BITS-1:0]   cnt_inc;
    logic [SUM_BITS-1:0]     upper;
    logic [SUM_BITS-1:0]     all_sum;
    logic [TOT_W-1:0]        total_sum;
    logic                    full_u;
    logic                    s_fire;
    logic                    cfg_fire;

    // trie node for a prefix of the given depth: (2^depth - 2) + prefix
    function automatic logic [ADDR_W-1:0] node_addr(
        input logic [LVL_W-1:0]    depth,
        input logic [KEY_BITS-1:0] prefix
    );
        logic [ADDR_W:0] base;
        base = ((ADDR_W + 1)'(1) << depth) - (ADDR_W + 1)'(2);
        return ADDR_W'(base + (ADDR_W + 1)'(prefix));
    endfunction

    xrpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (ram_raddr0),
        .rdata0 (ram_rdata0),
        .raddr1 (ram_raddr1),
        .rdata1 (ram_rdata1)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // key and bound bits for the current level
    assign shamt = LVL_W'(KEY_BITS) - lvl_reg;
    assign kb    = 1'(key_reg >> shamt);
    assign bit_u = 1'(32'(bound_u_reg) >> shamt);
    assign bit_l = 1'(32'(bound_l_reg) >> shamt);

    // entries from an older epoch read as zero
    assign cnt_rd0 = (ram_rdata0[ENTRY_W-1:COUNT_BITS] == epoch_reg) ?
                     ram_rdata0[COUNT_BITS-1:0] : '0;
    assign cnt_rd1 = (ram_rdata1[ENTRY_W-1:COUNT_BITS] == epoch_reg) ?
                     ram_rdata1[COUNT_BITS-1:0] : '0;
    assign cnt_inc = (cnt_rd0 == COUNT_MAX) ? COUNT_MAX : cnt_rd0 + COUNT_BITS'(1);

    // bound beyond the key range counts every stored key
    assign full_u    = (32'(bound_u_reg) >> KEY_BITS) != 32'd0;
    assign all_sum   = SUM_BITS'(cnt0_reg) + SUM_BITS'(cnt1_reg);
    assign upper     = full_u ? all_sum : sum_u_reg;
    assign total_sum = TOT_W'(total_reg) + TOT_W'(diff_reg);

    // ram port selection
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = ins_addr_reg;
        ram_wdata  = {epoch_reg, cnt_inc};
        ram_raddr0 = node_addr(lvl_reg, (cur_u_reg << 1) | KEY_BITS'(kb));
        ram_raddr1 = node_addr(lvl_reg, (cur_l_reg << 1) | KEY_BITS'(kb));
        unique case (state_reg)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            S_QRY: begin
                ram_we = (lvl_reg != LVL_W'(1));
            end
            S_INS: begin
                ram_raddr0 = node_addr(lvl_reg, key_reg >> shamt);
            end
            S_FIN: begin
                ram_we = 1'b1;
            end
            S_IDLE, S_TOT: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg;
        epoch_next      = epoch_reg;
        pend_next       = pend_reg;
        clr_next        = clr_reg;
        lvl_next        = lvl_reg;
        total_next      = total_reg;
        cnt0_next       = cnt0_reg;
        cnt1_next       = cnt1_reg;
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        key_next        = key_reg;
        bound_u_next    = bound_u_reg;
        bound_l_next    = bound_l_reg;
        cur_u_next      = cur_u_reg;
        cur_l_next      = cur_l_reg;
        bu_next         = bu_reg;
        bl_next         = bl_reg;
        sum_u_next      = sum_u_reg;
        sum_l_next      = sum_l_reg;
        ins_addr_next   = ins_addr_reg;
        diff_next       = diff_reg;
        m_data_next     = m_data_reg;

        // result beat taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_fire) begin
            unique case (cfg_index)
                CFG_RANGE_LOW:  range_low_next  = cfg_data;
                CFG_RANGE_HIGH: range_high_next = cfg_data;
                default:        range_low_next  = range_low_reg;
            endcase
        end

        unique case (state_reg)
            // sweep the store, then restart the epoch count
            S_CLR: begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(NODE_COUNT - 1)) begin
                    clr_next   = '0;
                    epoch_next = EPOCH_BITS'(1);
                    pend_next  = 1'b0;
                    state_next = pend_reg ? S_QRY : S_IDLE;
                end
            end
            // take a key and latch the bounds
            S_IDLE: begin
                if (s_fire) begin
                    key_next     = KEY_BITS'(s_data.value);
                    bound_u_next = {1'b0, range_high_reg} + (RANGE_BITS + 1)'(1);
                    bound_l_next = {1'b0, range_low_reg};
                    cur_u_next   = '0;
                    cur_l_next   = '0;
                    sum_u_next   = '0;
                    sum_l_next   = '0;
                    lvl_next     = LVL_W'(1);
                    state_next   = S_QRY;
                    if (s_data.start_new) begin
                        total_next = '0;
                        cnt0_next  = '0;
                        cnt1_next  = '0;
                        if (epoch_reg == EPOCH_MAX) begin
                            pend_next  = 1'b1;
                            state_next = S_CLR;
                        end else begin
                            epoch_next = epoch_reg + EPOCH_BITS'(1);
                        end
                    end
                end
            end
            // issue both bound walk reads, step the walk prefixes
            S_QRY: begin
                bu_next    = bit_u;
                bl_next    = bit_l;
                cur_u_next = (cur_u_reg << 1) | KEY_BITS'(kb ^ bit_u);
                cur_l_next = (cur_l_reg << 1) | KEY_BITS'(kb ^ bit_l);
                state_next = S_INS;
            end
            // issue the insert read, accumulate the walk counts
            S_INS: begin
                ins_addr_next = node_addr(lvl_reg, key_reg >> shamt);
                if (bu_reg) begin
                    sum_u_next = sum_u_reg + SUM_BITS'(cnt_rd0);
                end
                if (bl_reg) begin
                    sum_l_next = sum_l_reg + SUM_BITS'(cnt_rd1);
                end
                lvl_next   = lvl_reg + LVL_W'(1);
                state_next = (lvl_reg == LVL_W'(KEY_BITS)) ? S_FIN : S_QRY;
            end
            // last insert write, range count clamped at zero
            S_FIN: begin
                diff_next = (upper > sum_l_reg) ? upper - sum_l_reg : '0;
                if (key_reg[KEY_BITS-1]) begin
                    cnt1_next = (cnt1_reg == COUNT_MAX) ? COUNT_MAX :
                                cnt1_reg + COUNT_BITS'(1);
                end else begin
                    cnt0_next = (cnt0_reg == COUNT_MAX) ? COUNT_MAX :
                                cnt0_reg + COUNT_BITS'(1);
                end
                state_next = S_TOT;
            end
            // saturating total into the output register
            S_TOT: begin
                if (!m_valid_reg || m_ready) begin
                    total_next = (total_sum > TOT_W'(TOTAL_MAX)) ? TOTAL_MAX :
                                 TOTAL_BITS'(total_sum);
                    m_data_next.pair_total = total_next;
                    m_data_next.saturated  = (total_next == TOTAL_MAX);
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            m_valid_reg    <= 1'b0;
            epoch_reg      <= '0;
            pend_reg       <= 1'b0;
            clr_reg        <= '0;
            lvl_reg        <= '0;
            total_reg      <= '0;
            cnt0_reg       <= '0;
            cnt1_reg       <= '0;
            range_low_reg  <= RANGE_LOW_RST;
            range_high_reg <= RANGE_HIGH_RST;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            epoch_reg      <= epoch_next;
            pend_reg       <= pend_next;
            clr_reg        <= clr_next;
            lvl_reg        <= lvl_next;
            total_reg      <= total_next;
            cnt0_reg       <= cnt0_next;
            cnt1_reg       <= cnt1_next;
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        bound_u_reg  <= bound_u_next;
        bound_l_reg  <= bound_l_next;
        cur_u_reg    <= cur_u_next;
        cur_l_reg    <= cur_l_next;
        bu_reg       <= bu_next;
        bl_reg       <= bl_next;
        sum_u_reg    <= sum_u_next;
        sum_l_reg    <= sum_l_next;
        ins_addr_reg <= ins_addr_next;
        diff_reg     <= diff_next;
        m_data_reg   <= m_data_next;
    end

    // no key is taken while the store is being swept
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLR) |-> !s_ready)
        else $error("key accepted during clearing pass");

    // the trie walk stays within the key depth
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_QRY || state_reg == S_INS) |->
        (lvl_reg != '0 && lvl_reg <= LVL_W'(KEY_BITS)))
        else $error("trie level out of range");

    // epoch zero marks swept entries and is never live during a walk
    a_epoch_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_QRY || state_reg == S_INS || state_reg == S_FIN) |->
        (epoch_reg != '0))
        else $error("walk with a dead epoch");

    // saturated flag agrees with the reported total
    a_sat_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.saturated == (m_data_reg.pair_total == TOTAL_MAX)))
        else $error("saturated flag mismatch");

    // a new result is never loaded over an untaken one
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TOT && m_valid_reg && !m_ready) |=> (state_reg == S_TOT))
        else $error("result register overwritten");

endmodule
